FILE: src/xcpf_pkg.sv
// shared types and constants of the xor checksum packet framer
`default_nettype none

package xcpf_pkg;

  localparam logic [7:0] START_MARK = 8'h02;
  localparam logic [7:0] END_MARK   = 8'h03;
  localparam logic [7:0] ID_RESET   = 8'd3;
  localparam logic [7:0] ID_FIRST   = 8'd4;
  localparam logic [7:0] ID_LAST    = 8'd255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int STEP_W      = 3;

  typedef enum logic [2:0] {
    CMD_REJECT,
    CMD_HEAD,
    CMD_BYTE,
    CMD_BYTE_TRAIL,
    CMD_TRAIL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic [7:0] len;
    logic [7:0] id;
    logic [7:0] x_all;
    logic [7:0] x_even;
    logic [7:0] x_third;
  } cmd_t;

endpackage

`default_nettype wire

FILE: src/xor_checksum_packet_framer.sv
// top level of the xor checksum packet framer
// usage:
//   input side is a queue: drive payload_byte and payload_length with push high;
//   the request is taken on a clock edge where push is high and full is low.
//   payload_length is only looked at on the first byte of a frame.
//   output side is a queue: while empty is low the oldest result sits on
//   frame_byte, frame_done, length_rejected and run_last; pop high takes it.
//   each request yields 1 to 7 results, run_last marks the last of them.
//   a request's first result goes through the command queue and the output
//   register. one result is emitted per cycle unless the output register is
//   full and pop is low. a middle byte yields one result, a frame start six,
//   a last byte seven, a reject one, the flush after a one-byte frame six.
//   a four-entry command queue lets the front keep taking requests while the
//   back end works through a header or trailer burst; full rises when it fills.
//   when pop is held low the output register holds, the queue fills, then
//   full holds off further requests; nothing is dropped.
//   rst (synchronous) clears frame state, the queue and the output valid flag;
//   the next packet id after reset is 4.
`default_nettype none

module xor_checksum_packet_framer import xcpf_pkg::*; #(
  parameter int PACKET_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] payload_byte,
  input  wire logic [7:0] payload_length,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      frame_byte,
  output logic            frame_done,
  output logic            length_rejected,
  output logic            run_last
);

  cmd_t wr_cmd, rd_cmd;
  logic q_wr, q_rd, q_empty;

  xcpf_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .payload_byte   (payload_byte),
    .payload_length (payload_length),
    .q_full         (full),
    .q_wr           (q_wr),
    .q_cmd          (wr_cmd)
  );

  xcpf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (wr_cmd),
    .full   (full),
    .rd     (q_rd),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  xcpf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_cmd           (rd_cmd),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .pop             (pop),
    .empty           (empty),
    .frame_byte      (frame_byte),
    .frame_done      (frame_done),
    .length_rejected (length_rejected),
    .run_last        (run_last)
  );

endmodule

`default_nettype wire

FILE: src/xcpf_front.sv
// front end: accepts payload bytes, tracks frame state and builds commands
`default_nettype none

module xcpf_front import xcpf_pkg::*; #(
  parameter int PACKET_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] payload_byte,
  input  wire logic [7:0] payload_length,
  input  wire logic       q_full,
  output logic            q_wr,
  output cmd_t            q_cmd
);

  localparam int BL_W = $clog2(PACKET_BYTES - 10);
  localparam logic [7:0] MAX_PAYLOAD = 8'(PACKET_BYTES - 11);

  logic            inside_frame, inside_frame_next;
  logic            trailer_owed, trailer_owed_next;
  logic [BL_W-1:0] bytes_left, bytes_left_next;
  logic            index_parity, index_parity_next;
  logic [1:0]      index_mod_three, index_mod_three_next;
  logic [7:0]      xor_every_byte, xor_every_byte_next;
  logic [7:0]      xor_even_bytes, xor_even_bytes_next;
  logic [7:0]      xor_third_bytes, xor_third_bytes_next;
  logic [7:0]      last_issued_id, last_issued_id_next;

  logic [7:0]      new_id;
  logic [7:0]      len_m1;
  logic [BL_W-1:0] bl_dec;
  logic [7:0]      nx_all, nx_even, nx_third;

  assign q_wr = push && !q_full;

  always_comb begin
    new_id = (last_issued_id >= ID_LAST || last_issued_id < ID_RESET) ? ID_FIRST
             : last_issued_id + 8'd1;
    len_m1   = payload_length - 8'd1;
    bl_dec   = bytes_left - BL_W'(1);
    nx_all   = xor_every_byte ^ payload_byte;
    nx_even  = index_parity ? xor_even_bytes : (xor_even_bytes ^ payload_byte);
    nx_third = (index_mod_three == 2'd0) ? (xor_third_bytes ^ payload_byte)
               : xor_third_bytes;

    inside_frame_next    = inside_frame;
    trailer_owed_next    = trailer_owed;
    bytes_left_next      = bytes_left;
    index_parity_next    = index_parity;
    index_mod_three_next = index_mod_three;
    xor_every_byte_next  = xor_every_byte;
    xor_even_bytes_next  = xor_even_bytes;
    xor_third_bytes_next = xor_third_bytes;
    last_issued_id_next  = last_issued_id;

    q_cmd.kind    = CMD_BYTE;
    q_cmd.data    = payload_byte;
    q_cmd.len     = payload_length;
    q_cmd.id      = new_id;
    q_cmd.x_all   = nx_all;
    q_cmd.x_even  = nx_even;
    q_cmd.x_third = nx_third;

    if (trailer_owed) begin
      // flush slot of a one-byte frame, input ignored
      q_cmd.kind           = CMD_TRAIL;
      q_cmd.x_all          = xor_every_byte;
      q_cmd.x_even         = xor_even_bytes;
      q_cmd.x_third        = xor_third_bytes;
      trailer_owed_next    = 1'b0;
      xor_every_byte_next  = '0;
      xor_even_bytes_next  = '0;
      xor_third_bytes_next = '0;
      index_parity_next    = 1'b0;
      index_mod_three_next = '0;
    end else if (!inside_frame) begin
      if (payload_length == 8'd0 || payload_length > MAX_PAYLOAD) begin
        q_cmd.kind = CMD_REJECT;
      end else begin
        q_cmd.kind           = CMD_HEAD;
        last_issued_id_next  = new_id;
        xor_every_byte_next  = payload_byte;
        xor_even_bytes_next  = payload_byte;
        xor_third_bytes_next = payload_byte;
        index_parity_next    = 1'b1;
        index_mod_three_next = 2'd1;
        bytes_left_next      = len_m1[BL_W-1:0];
        if (payload_length == 8'd1) begin
          trailer_owed_next = 1'b1;
        end else begin
          inside_frame_next = 1'b1;
        end
      end
    end else begin
      bytes_left_next = bl_dec;
      if (bl_dec == '0) begin
        q_cmd.kind           = CMD_BYTE_TRAIL;
        inside_frame_next    = 1'b0;
        xor_every_byte_next  = '0;
        xor_even_bytes_next  = '0;
        xor_third_bytes_next = '0;
        index_parity_next    = 1'b0;
        index_mod_three_next = '0;
      end else begin
        q_cmd.kind           = CMD_BYTE;
        xor_every_byte_next  = nx_all;
        xor_even_bytes_next  = nx_even;
        xor_third_bytes_next = nx_third;
        index_parity_next    = !index_parity;
        index_mod_three_next = (index_mod_three >= 2'd2) ? 2'd0 : index_mod_three + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame    <= 1'b0;
      trailer_owed    <= 1'b0;
      bytes_left      <= '0;
      index_parity    <= 1'b0;
      index_mod_three <= '0;
      xor_every_byte  <= '0;
      xor_even_bytes  <= '0;
      xor_third_bytes <= '0;
      last_issued_id  <= ID_RESET;
    end else if (q_wr) begin
      inside_frame    <= inside_frame_next;
      trailer_owed    <= trailer_owed_next;
      bytes_left      <= bytes_left_next;
      index_parity    <= index_parity_next;
      index_mod_three <= index_mod_three_next;
      xor_every_byte  <= xor_every_byte_next;
      xor_even_bytes  <= xor_even_bytes_next;
      xor_third_bytes <= xor_third_bytes_next;
      last_issued_id  <= last_issued_id_next;
    end
  end

  a_owed_outside: assert property (@(posedge clk) disable iff (rst)
    !(inside_frame && trailer_owed))
    else $error("trailer owed while inside a frame");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !inside_frame |-> bytes_left == '0)
    else $error("bytes left outside a frame");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    q_wr && q_cmd.kind == CMD_HEAD |=> last_issued_id >= ID_FIRST)
    else $error("issued id below first id");

endmodule

`default_nettype wire

FILE: src/xcpf_queue.sv
// short command queue between front and back end
`default_nettype none

module xcpf_queue import xcpf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic rd,
  output cmd_t      rd_cmd,
  output logic      empty
);

  cmd_t            slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QA_W:0]   count, count_next;

  assign full   = (count == (QA_W+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr && !rd) begin
      count_next = count + (QA_W+1)'(1);
    end else if (rd && !wr) begin
      count_next = count - (QA_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QA_W+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty)
    else $error("queue read while empty");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("queue write while full");

endmodule

`default_nettype wire

FILE: src/xcpf_back.sv
// back end: expands commands into framed bytes through an output register
`default_nettype none

module xcpf_back import xcpf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  q_cmd,
  input  wire logic  q_empty,
  output logic       q_rd,
  input  wire logic  pop,
  output logic       empty,
  output logic [7:0] frame_byte,
  output logic       frame_done,
  output logic       length_rejected,
  output logic       run_last
);

  logic [STEP_W-1:0] step, step_next;
  logic              out_valid;
  logic              load;
  logic [7:0]        r_byte;
  logic              r_done, r_rej, r_last;

  function automatic logic [7:0] trailer_byte(input cmd_t c, input logic [STEP_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      STEP_W'(0): b = c.x_all;
      STEP_W'(1): b = c.x_even;
      STEP_W'(2): b = c.x_third;
      default:    b = END_MARK;
    endcase
    return b;
  endfunction

  always_comb begin
    r_byte = q_cmd.data;
    r_done = 1'b0;
    r_rej  = 1'b0;
    r_last = 1'b0;
    unique case (q_cmd.kind)
      CMD_REJECT: begin
        r_byte = 8'd0;
        r_rej  = 1'b1;
        r_last = 1'b1;
      end
      CMD_HEAD: begin
        if (step < STEP_W'(3)) begin
          r_byte = START_MARK;
        end else if (step == STEP_W'(3)) begin
          r_byte = q_cmd.len;
        end else if (step == STEP_W'(4)) begin
          r_byte = q_cmd.id;
        end else begin
          r_byte = q_cmd.data;
          r_last = 1'b1;
        end
      end
      CMD_BYTE: begin
        r_last = 1'b1;
      end
      CMD_BYTE_TRAIL: begin
        if (step != '0) begin
          r_byte = trailer_byte(q_cmd, step - STEP_W'(1));
          r_done = (step == STEP_W'(6));
          r_last = r_done;
        end
      end
      CMD_TRAIL: begin
        r_byte = trailer_byte(q_cmd, step);
        r_done = (step == STEP_W'(5));
        r_last = r_done;
      end
      default: begin
        r_last = 1'b1;
      end
    endcase

    load      = !q_empty && (!out_valid || pop);
    q_rd      = load && r_last;
    step_next = step;
    if (load) begin
      step_next = r_last ? '0 : step + STEP_W'(1);
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte      <= r_byte;
      frame_done      <= r_done;
      length_rejected <= r_rej;
      run_last        <= r_last;
    end
  end

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last && frame_byte == END_MARK)
    else $error("frame done off the last end mark");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_rejected |-> run_last && frame_byte == 8'd0)
    else $error("bad reject result");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_W'(6))
    else $error("step out of range");

endmodule

`default_nettype wire

FILE: bench/xcpf_stream_checker.sv
// stream checker for the xor checksum packet framer: predicts framed bytes and compares results
module xcpf_stream_checker import xcpf_pkg::*; #(
  parameter int PACKET_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] payload_byte,
  input  logic [7:0] payload_length,
  input  logic       pop,
  input  logic       empty,
  input  logic [7:0] frame_byte,
  input  logic       frame_done,
  input  logic       length_rejected,
  input  logic       run_last,
  output int         failures,
  output int         pending,
  output int         results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD = PACKET_BYTES - 11;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       rej;
    logic       tail;
  } framed_out_t;

  framed_out_t framed_q[$];

  logic       in_frame;
  logic [5:0] bytes_left;
  logic       odd_index;
  logic [1:0] third_phase;
  logic [7:0] sum_all;
  logic [7:0] sum_even;
  logic [7:0] sum_third;
  logic [7:0] last_id;
  logic       trailer_owed;
  int         fail_count = 0;
  int         result_count = 0;

  function automatic void queue_byte(input logic [7:0] data, input logic done,
                                     input logic rej);
    framed_out_t r;
    r.data = data;
    r.done = done;
    r.rej  = rej;
    r.tail = 1'b0;
    framed_q.push_back(r);
  endfunction

  function automatic void queue_trailer();
    queue_byte(sum_all, 1'b0, 1'b0);
    queue_byte(sum_even, 1'b0, 1'b0);
    queue_byte(sum_third, 1'b0, 1'b0);
    queue_byte(END_MARK, 1'b0, 1'b0);
    queue_byte(END_MARK, 1'b0, 1'b0);
    queue_byte(END_MARK, 1'b1, 1'b0);
    sum_all      = '0;
    sum_even     = '0;
    sum_third    = '0;
    odd_index    = 1'b0;
    third_phase  = '0;
    trailer_owed = 1'b0;
  endfunction

  function automatic void frame_request(input logic [7:0] b, input logic [7:0] len);
    logic opened;
    opened = 1'b0;
    if (trailer_owed) begin
      queue_trailer();
    end else if (!in_frame && (len == 0 || len > MAX_PAYLOAD)) begin
      queue_byte(8'h00, 1'b0, 1'b1);
    end else begin
      if (!in_frame) begin
        if (last_id == ID_LAST || last_id < ID_RESET) begin
          last_id = ID_FIRST;
        end else begin
          last_id = last_id + 8'd1;
        end
        queue_byte(START_MARK, 1'b0, 1'b0);
        queue_byte(START_MARK, 1'b0, 1'b0);
        queue_byte(START_MARK, 1'b0, 1'b0);
        queue_byte(len, 1'b0, 1'b0);
        queue_byte(last_id, 1'b0, 1'b0);
        sum_all     = '0;
        sum_even    = '0;
        sum_third   = '0;
        odd_index   = 1'b0;
        third_phase = '0;
        bytes_left  = len[5:0];
        in_frame    = 1'b1;
        opened      = 1'b1;
      end
      sum_all = sum_all ^ b;
      if (!odd_index) begin
        sum_even = sum_even ^ b;
      end
      if (third_phase == 2'd0) begin
        sum_third = sum_third ^ b;
      end
      odd_index   = ~odd_index;
      third_phase = (third_phase >= 2'd2) ? 2'd0 : third_phase + 2'd1;
      queue_byte(b, 1'b0, 1'b0);
      if (bytes_left > 0) begin
        bytes_left = bytes_left - 6'd1;
      end
      if (bytes_left == 0) begin
        in_frame = 1'b0;
        if (opened) begin
          trailer_owed = 1'b1;
        end else begin
          queue_trailer();
        end
      end
    end
    framed_q[framed_q.size() - 1].tail = 1'b1;
  endfunction

  always @(posedge clk) begin
    framed_out_t want;
    if (rst) begin
      framed_q.delete();
      in_frame     = 1'b0;
      bytes_left   = '0;
      odd_index    = 1'b0;
      third_phase  = '0;
      sum_all      = '0;
      sum_even     = '0;
      sum_third    = '0;
      last_id      = ID_RESET;
      trailer_owed = 1'b0;
    end else begin
      if (pop && !empty) begin
        result_count++;
        if (framed_q.size() == 0) begin
          $error("unexpected result: frame_byte %0h", frame_byte);
          fail_count++;
        end else begin
          want = framed_q.pop_front();
          if (frame_byte !== want.data) begin
            $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
            fail_count++;
          end
          if (frame_done !== want.done) begin
            $error("frame_done: expected %0b, got %0b", want.done, frame_done);
            fail_count++;
          end
          if (length_rejected !== want.rej) begin
            $error("length_rejected: expected %0b, got %0b", want.rej, length_rejected);
            fail_count++;
          end
          if (run_last !== want.tail) begin
            $error("run_last: expected %0b, got %0b", want.tail, run_last);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        frame_request(payload_byte, payload_length);
      end
    end
    failures     <= fail_count;
    pending      <= framed_q.size();
    results_seen <= result_count;
  end

endmodule

FILE: bench/xor_checksum_packet_framer_test.sv
// testbench top for the xor checksum packet framer: stimulus, flow control and verdict
module xor_checksum_packet_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PACKET_BYTES = 64;
  localparam int MAX_PAYLOAD  = PACKET_BYTES - 11;
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [7:0] payload_byte = 8'h00;
  logic [7:0] payload_length = 8'h00;
  logic       full;
  logic       empty;
  logic [7:0] frame_byte;
  logic       frame_done;
  logic       length_rejected;
  logic       run_last;

  int   failures;
  int   pending;
  int   results_seen;
  int   sent = 0;
  int   frames = 0;
  int   rejects = 0;
  int   burst_left = 0;
  int   hold_asks = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;
  int   idle_cycles = 0;
  logic request_taken = 1'b0;
  logic drained = 1'b0;

  always #4 clk = ~clk;

  xor_checksum_packet_framer #(.PACKET_BYTES(PACKET_BYTES)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .payload_byte(payload_byte), .payload_length(payload_length),
    .pop(pop), .empty(empty), .frame_byte(frame_byte), .frame_done(frame_done),
    .length_rejected(length_rejected), .run_last(run_last)
  );

  xcpf_stream_checker #(.PACKET_BYTES(PACKET_BYTES)) checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .payload_byte(payload_byte), .payload_length(payload_length),
    .pop(pop), .empty(empty), .frame_byte(frame_byte), .frame_done(frame_done),
    .length_rejected(length_rejected), .run_last(run_last),
    .failures(failures), .pending(pending), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    request_taken <= push && !full;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("xor_checksum_packet_framer verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(20, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ~pop;
      endcase
    end
  end

  task automatic send(input logic [7:0] b, input logic [7:0] len);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    push <= 1'b1;
    payload_byte <= b;
    payload_length <= len;
    do @(negedge clk); while (!request_taken);
    sent++;
  endtask

  task automatic send_frame(input int len);
    send(8'($urandom_range(0, 255)), 8'(len));
    for (int i = 1; i < len; i++) begin
      send(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    // a one-byte frame owes its trailer on the following request
    if (len == 1) begin
      send(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    frames++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    int pick;
    int len;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(8'hA5, 8'd0);
    send(8'h5A, 8'(MAX_PAYLOAD + 1));
    send(8'hFF, 8'hFF);
    rejects += 3;
    send(8'h00, 8'd1);
    send(8'h77, 8'd0);
    send(8'h80, 8'd1);
    send(8'h12, 8'hFF);
    send(8'hFF, 8'd2);
    send(8'h00, 8'hFF);
    send(8'hFF, 8'd3);
    send(8'hFF, 8'd0);
    send(8'hFF, 8'h00);
    for (int i = 0; i < 7; i++) begin
      send(8'h01 << i, (i == 0) ? 8'd7 : 8'h80 >> i);
    end
    frames += 5;

    while (sent < 360) begin
      if (sent >= 120 && hold_asks == 0) begin
        hold_asks <= 1;
      end
      if (sent >= 250 && !drained) begin
        drained = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send(8'($urandom_range(0, 255)),
             $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        rejects++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len = 1;
        end else if (pick < 85) begin
          len = $urandom_range(2, 4);
        end else if (pick < 97) begin
          len = $urandom_range(5, 12);
        end else begin
          len = $urandom_range(0, 1) ? MAX_PAYLOAD : $urandom_range(13, MAX_PAYLOAD);
        end
        send_frame(len);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);

    $display("%0d requests sent: %0d frames (one-byte frames with flush slots included), %0d length rejects",
             sent, frames, rejects);
    $display("%0d results compared, with a long receiver hold-off and a full drain pause",
             results_seen);
    if (failures == 0 && pending == 0) begin
      $display("xor_checksum_packet_framer verification clean");
    end else begin
      $display("xor_checksum_packet_framer verification failed");
    end
    $finish;
  end

endmodule
